// ===== rtl/cfrv_pkg.sv =====
// Shared types, codes and constants of the command frame receiver.
// No dependencies; used by every file under rtl.
package cfrv_pkg;

    localparam int STORE_DEPTH = 14;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int COPIES      = 5;
    localparam int VOTE_NEED   = 3;
    localparam int VCNT_W      = $clog2(COPIES + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]  MIN_FREQ_LEN   = 8'd14;
    localparam logic [31:0] INTERVAL_RESET = 32'd170000;

    // input beat selector
    localparam logic [1:0] FUNC_BYTE    = 2'd0;
    localparam logic [1:0] FUNC_SESSION = 2'd1;
    localparam logic [1:0] FUNC_COMMIT  = 2'd2;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_SYNC      = 2'd0;
    localparam logic [1:0] REG_HIGHEST   = 2'd1;
    localparam logic [1:0] REG_SET_FREQ  = 2'd2;
    localparam logic [1:0] REG_FAILLIMIT = 2'd3;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CSUM_ERR = 3'd1,
        ST_FREQ_OK  = 3'd2,
        ST_VOTED    = 3'd3,
        ST_FALLBACK = 3'd4,
        ST_SHORT    = 3'd5,
        ST_STOP     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        KIND_FRAME   = 2'd0,
        KIND_SESSION = 2'd1,
        KIND_COMMIT  = 2'd2
    } kind_t;

    // one queued job: a finished frame, a session start or a commit notice
    typedef struct packed {
        kind_t                         kind;
        logic                          sum_ok;
        logic [7:0]                    command;
        logic [7:0]                    length;
        logic [STORE_DEPTH-1:0][7:0]   payload;  // bytes past length are zero
        logic [15:0]                   freq;
    } entry_t;

    typedef struct packed {
        logic [7:0] sync_value;
        logic [7:0] highest_command;
        logic [7:0] set_frequency_code;
        logic [7:0] fail_limit;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic full;
    } qstat_t;

endpackage

// ===== rtl/cfrv_front.sv =====
// Front end: accepts input beats, runs the frame parser and pushes jobs.
// Depends on cfrv_pkg.
module cfrv_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfrv_pkg::cfg_t      cfg,
    input  logic                in_valid,
    input  logic [1:0]          in_func,
    input  logic [7:0]          in_byte,
    input  logic [15:0]         in_freq,
    input  logic                q_full,
    output logic                in_ready,
    output logic                push,
    output cfrv_pkg::entry_t    push_entry
);

    typedef enum logic [4:0] {
        PH_SYNC = 5'b00001,
        PH_CMD  = 5'b00010,
        PH_LEN  = 5'b00100,
        PH_DATA = 5'b01000,
        PH_SUM  = 5'b10000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] idx_reg, idx_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] store_reg [cfrv_pkg::STORE_DEPTH];
    logic       accept;
    logic       store_we;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign store_we = accept && (in_func == cfrv_pkg::FUNC_BYTE) && (phase_reg == PH_DATA)
                      && (idx_reg < 8'(cfrv_pkg::STORE_DEPTH));

    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        xor_next   = xor_reg;
        push       = 1'b0;

        push_entry.kind    = cfrv_pkg::KIND_FRAME;
        push_entry.sum_ok  = (in_byte == xor_reg);
        push_entry.command = cmd_reg;
        push_entry.length  = len_reg;
        push_entry.freq    = in_freq;
        for (int i = 0; i < cfrv_pkg::STORE_DEPTH; i++) begin
            push_entry.payload[i] = (8'(i) < len_reg) ? store_reg[i] : 8'h00;
        end

        if (accept) begin
            unique case (in_func)
                cfrv_pkg::FUNC_SESSION: begin
                    push            = 1'b1;
                    push_entry.kind = cfrv_pkg::KIND_SESSION;
                end
                cfrv_pkg::FUNC_COMMIT: begin
                    push            = 1'b1;
                    push_entry.kind = cfrv_pkg::KIND_COMMIT;
                end
                cfrv_pkg::FUNC_BYTE: begin
                    unique case (phase_reg)
                        PH_CMD: begin
                            if (in_byte == 8'h00 || in_byte > cfg.highest_command) begin
                                // bad command: drop the sync, rescan this byte
                                if (in_byte == cfg.sync_value) begin
                                    xor_next   = in_byte;
                                    phase_next = PH_CMD;
                                end else begin
                                    phase_next = PH_SYNC;
                                end
                            end else begin
                                cmd_next   = in_byte;
                                xor_next   = xor_reg ^ in_byte;
                                phase_next = PH_LEN;
                            end
                        end
                        PH_LEN: begin
                            len_next   = in_byte;
                            xor_next   = xor_reg ^ in_byte;
                            idx_next   = 8'd0;
                            phase_next = (in_byte == 8'h00) ? PH_SUM : PH_DATA;
                        end
                        PH_DATA: begin
                            xor_next = xor_reg ^ in_byte;
                            idx_next = idx_reg + 8'd1;
                            if (idx_reg + 8'd1 >= len_reg) begin
                                phase_next = PH_SUM;
                            end
                        end
                        PH_SUM: begin
                            push       = 1'b1;
                            phase_next = PH_SYNC;
                        end
                        default: begin
                            if (in_byte == cfg.sync_value) begin
                                xor_next   = in_byte;
                                phase_next = PH_CMD;
                            end else begin
                                phase_next = PH_SYNC;
                            end
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SYNC;
            cmd_reg   <= 8'd0;
            len_reg   <= 8'd0;
            idx_reg   <= 8'd0;
            xor_reg   <= 8'd0;
        end else begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            xor_reg   <= xor_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[idx_reg[cfrv_pkg::IDX_W-1:0]] <= in_byte;
        end
    end

endmodule

// ===== rtl/cfrv_queue.sv =====
// Short job queue between the parser and the recovery back end.
// Depends on cfrv_pkg.
module cfrv_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  cfrv_pkg::entry_t   push_entry,
    input  logic               pop,
    output cfrv_pkg::qstat_t   qstat,
    output cfrv_pkg::entry_t   head
);

    localparam int PTR_W = (cfrv_pkg::QUEUE_DEPTH > 1) ? $clog2(cfrv_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(cfrv_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(cfrv_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(cfrv_pkg::QUEUE_DEPTH);

    cfrv_pkg::entry_t  mem_reg [cfrv_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign qstat.valid = (count_reg != '0);
    assign qstat.full  = (count_reg == FULL_CNT);
    assign head        = mem_reg[rd_ptr_reg];
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && qstat.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/cfrv_back.sv =====
// Back end: frequency recovery (vote, fallback, time extrapolation), failure
// counting and the registered result beat. Depends on cfrv_pkg.
module cfrv_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfrv_pkg::cfg_t     cfg,
    input  cfrv_pkg::qstat_t   qstat,
    input  cfrv_pkg::entry_t   head,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [111:0]       m_tdata,
    output logic [2:0]         m_tuser
);

    logic [7:0]  fail_reg, fail_next;
    logic [31:0] prev_reg, prev_next;
    logic [31:0] ival_reg, ival_next;
    logic [15:0] lastf_reg, lastf_next;
    logic        out_valid_reg, out_valid_next;
    logic [111:0] out_data_reg;
    logic [2:0]   out_user_reg;

    logic [15:0]               copies [cfrv_pkg::COPIES];
    logic [cfrv_pkg::VCNT_W-1:0] vcnt [cfrv_pkg::COPIES];
    logic                      vote_found;
    logic [15:0]               vote_freq;
    logic [7:0]                fail_inc;
    logic [31:0]               stamp_rx;
    logic [31:0]               stamp_ex;
    logic                      is_frame;
    cfrv_pkg::status_t         status;
    logic [15:0]               freq;
    logic [31:0]               stamp;
    logic [31:0]               head_word;

    assign pop      = qstat.valid && (!out_valid_reg || m_tready);
    assign is_frame = (head.kind == cfrv_pkg::KIND_FRAME);
    assign fail_inc = (fail_reg == 8'hFF) ? fail_reg : fail_reg + 8'd1;
    assign stamp_rx = {head.payload[10], head.payload[11], head.payload[12], head.payload[13]};
    assign stamp_ex = prev_reg + ival_reg;
    assign head_word = {head.payload[0], head.payload[1], head.payload[2], head.payload[3]};

    // 3-of-N vote: count matches per copy, first copy in order with enough wins
    always_comb begin
        for (int i = 0; i < cfrv_pkg::COPIES; i++) begin
            copies[i] = {head.payload[2*i], head.payload[2*i+1]};
        end
        for (int i = 0; i < cfrv_pkg::COPIES; i++) begin
            vcnt[i] = '0;
            for (int j = 0; j < cfrv_pkg::COPIES; j++) begin
                if (copies[j] == copies[i]) begin
                    vcnt[i] = vcnt[i] + cfrv_pkg::VCNT_W'(1);
                end
            end
        end
        vote_found = 1'b0;
        vote_freq  = 16'd0;
        for (int i = cfrv_pkg::COPIES - 1; i >= 0; i--) begin
            if (vcnt[i] >= cfrv_pkg::VCNT_W'(cfrv_pkg::VOTE_NEED)) begin
                vote_found = 1'b1;
                vote_freq  = copies[i];
            end
        end
    end

    always_comb begin
        fail_next  = fail_reg;
        prev_next  = prev_reg;
        ival_next  = ival_reg;
        lastf_next = lastf_reg;
        status     = cfrv_pkg::ST_OK;
        freq       = 16'd0;
        stamp      = 32'd0;

        if (head.command != cfg.set_frequency_code) begin
            status = head.sum_ok ? cfrv_pkg::ST_OK : cfrv_pkg::ST_CSUM_ERR;
        end else if (head.length < cfrv_pkg::MIN_FREQ_LEN) begin
            status = cfrv_pkg::ST_SHORT;
        end else if (head.sum_ok) begin
            status    = cfrv_pkg::ST_FREQ_OK;
            fail_next = 8'd0;
            freq      = copies[0];
            stamp     = stamp_rx;
            if (prev_reg != 32'd0 && stamp_rx > prev_reg) begin
                ival_next = stamp_rx - prev_reg;
            end
            prev_next = stamp_rx;
        end else begin
            fail_next = fail_inc;
            if (fail_inc >= cfg.fail_limit) begin
                status = cfrv_pkg::ST_STOP;
            end else begin
                if (vote_found) begin
                    status = cfrv_pkg::ST_VOTED;
                    freq   = vote_freq;
                end else begin
                    status = cfrv_pkg::ST_FALLBACK;
                    freq   = lastf_reg;
                end
                stamp     = stamp_ex;
                prev_next = stamp_ex;
            end
        end

        // non-frame jobs override the frame path
        unique case (head.kind)
            cfrv_pkg::KIND_SESSION: begin
                fail_next  = 8'd0;
                prev_next  = 32'd0;
                ival_next  = cfrv_pkg::INTERVAL_RESET;
                lastf_next = 16'd0;
            end
            cfrv_pkg::KIND_COMMIT: begin
                fail_next  = fail_reg;
                prev_next  = prev_reg;
                ival_next  = ival_reg;
                lastf_next = head.freq;
            end
            cfrv_pkg::KIND_FRAME: begin
            end
            default: begin
                fail_next  = fail_reg;
                prev_next  = prev_reg;
                ival_next  = ival_reg;
            end
        endcase

        out_valid_next = (out_valid_reg && !m_tready) || (pop && is_frame);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fail_reg      <= 8'd0;
            prev_reg      <= 32'd0;
            ival_reg      <= cfrv_pkg::INTERVAL_RESET;
            lastf_reg     <= 16'd0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                fail_reg  <= fail_next;
                prev_reg  <= prev_next;
                ival_reg  <= ival_next;
                lastf_reg <= lastf_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && is_frame) begin
            out_user_reg <= status;
            out_data_reg <= {fail_next, stamp, freq, head.payload[4], head_word,
                             head.length, head.command};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== rtl/command_frame_receiver_with_vote_unit.sv =====
// Top level of the command frame receiver with redundant frequency vote.
// Depends on cfrv_pkg, cfrv_front, cfrv_queue and cfrv_back.
//
// Use:
//   s_ carries input beats: s_tuser selects a received byte, a session start
//   or a frequency-committed notice; s_tdata holds the byte and the frequency.
//   m_ carries one result beat per finished frame (checksum byte received);
//   m_tuser is the frame status. Session and commit beats give no result.
//   The APB port holds sync value, highest command, set-frequency code and
//   fail limit at byte addresses 0, 4, 8 and 12; write only while idle.
// Timing:
//   One input beat per cycle while the queue is not full. The parser pushes
//   each finished frame as a job into a two-deep queue; the back end takes it
//   from the queue head and loads the result register.
// Reset (aresetn low, synchronous): parser waits for sync, queue and result
//   register empty, recovery state at its session defaults, registers reset.
// Stall: while m_tready is low the result register holds and the back end
//   stops; the queue absorbs two more jobs, then s_tready drops.
module command_frame_receiver_with_vote_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // input beats
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // data_byte[7:0], committed_freq[23:8]
    input  logic [1:0]   s_tuser,   // func[1:0]
    // result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    // command[7:0], payload_length[15:8], head_word[47:16], fifth_byte[55:48],
    // frequency[71:56], apply_time[103:72], fail_count[111:104]
    output logic [111:0] m_tdata,
    output logic [2:0]   m_tuser,   // status[2:0]
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cfrv_pkg::cfg_t   cfg_reg;
    cfrv_pkg::qstat_t qstat;
    cfrv_pkg::entry_t push_entry;
    cfrv_pkg::entry_t head;
    logic             push;
    logic             pop;
    logic             cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_value         <= 8'd170;
            cfg_reg.highest_command    <= 8'd255;
            cfg_reg.set_frequency_code <= 8'd1;
            cfg_reg.fail_limit         <= 8'd3;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                cfrv_pkg::REG_SYNC:      cfg_reg.sync_value         <= pwdata[7:0];
                cfrv_pkg::REG_HIGHEST:   cfg_reg.highest_command    <= pwdata[7:0];
                cfrv_pkg::REG_SET_FREQ:  cfg_reg.set_frequency_code <= pwdata[7:0];
                cfrv_pkg::REG_FAILLIMIT: cfg_reg.fail_limit         <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            cfrv_pkg::REG_SYNC:      prdata = {24'd0, cfg_reg.sync_value};
            cfrv_pkg::REG_HIGHEST:   prdata = {24'd0, cfg_reg.highest_command};
            cfrv_pkg::REG_SET_FREQ:  prdata = {24'd0, cfg_reg.set_frequency_code};
            cfrv_pkg::REG_FAILLIMIT: prdata = {24'd0, cfg_reg.fail_limit};
        endcase
    end

    cfrv_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_func    (s_tuser),
        .in_byte    (s_tdata[7:0]),
        .in_freq    (s_tdata[23:8]),
        .q_full     (qstat.full),
        .in_ready   (s_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    cfrv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .qstat      (qstat),
        .head       (head)
    );

    cfrv_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .qstat    (qstat),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // a result only appears after the back end took a job
    a_result_from_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(pop))
        else $error("result beat without a popped job");

    a_full_is_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.full |-> qstat.valid)
        else $error("queue full and empty at once");

    // a session start beat must land in the queue, never be dropped
    a_session_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == cfrv_pkg::FUNC_SESSION) |=> qstat.valid)
        else $error("session start beat lost");

endmodule
